@@ hw/rtl/dapsk_pkg.sv @@
package dapsk_pkg;

  localparam int DEF_SINE_ADDR_BITS  = 10;
  localparam int DEF_PHASE_FRAC_BITS = 32;
  localparam int PHASE_INT_BITS      = 6;

  localparam int INC_W    = 32;
  localparam int CPS_W    = 6;
  localparam int TRAIN_W  = 8;
  localparam int CFG_W    = 32;
  localparam int SINE_W   = 14;
  localparam int SAMPLE_W = 16;

  localparam logic [INC_W-1:0]   RST_PHASE_INC  = 32'd268435456;
  localparam logic [CPS_W-1:0]   RST_CYCLES     = 6'd8;
  localparam logic [TRAIN_W-1:0] RST_TRAINING   = 8'd16;
  localparam logic [TRAIN_W-1:0] TRAIN_CNT_MAX  = 8'hFF;

  localparam logic [SINE_W-1:0] SINE_SCALE   = 14'd8192;
  localparam logic [63:0]       Q30_ONE      = 64'd1 << 30;
  localparam logic [63:0]       Q30_HALF_PI  = 64'd1686629713;

  typedef enum logic [1:0] {
    CFG_PHASE_INC = 2'd0,
    CFG_CYCLES    = 2'd1,
    CFG_TRAINING  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic high_amp;
    logic symbol_taken;
    logic in_training;
  } dapsk_flags_t;

  // First-quadrant sine entry: Q30 Taylor series to x^13, rounded, capped.
  function automatic logic [SINE_W-1:0] quarter_sine(input int m, input int abits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] d;
    logic [63:0] s;
    logic [63:0] v;
    x  = (64'(m) * Q30_HALF_PI) >> (abits - 2);
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    d  = ((x2 * t) >> 30) / 64'd156;
    t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
    d  = ((x2 * t) >> 30) / 64'd110;
    t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
    d  = ((x2 * t) >> 30) / 64'd72;
    t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
    d  = ((x2 * t) >> 30) / 64'd42;
    t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
    d  = ((x2 * t) >> 30) / 64'd20;
    t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
    d  = ((x2 * t) >> 30) / 64'd6;
    t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
    s  = (x * t) >> 30;
    v  = (s * 64'(SINE_SCALE) + (Q30_ONE >> 1)) >> 30;
    if (v > 64'(SINE_SCALE)) begin
      v = 64'(SINE_SCALE);
    end
    return v[SINE_W-1:0];
  endfunction

endpackage

@@ hw/rtl/dapsk_in_if.sv @@
interface dapsk_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [2:0] symbol;
  logic       symbol_present;

  modport source (output valid, output cmd, output symbol, output symbol_present,
                  input ready);
  modport sink (input valid, input cmd, input symbol, input symbol_present,
                output ready);
endinterface

@@ hw/rtl/dapsk_out_if.sv @@
interface dapsk_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               symbol_taken;
  logic               in_training;

  modport source (output valid, output sample, output symbol_taken, output in_training,
                  input ready);
  modport sink (input valid, input sample, input symbol_taken, input in_training,
                output ready);
endinterface

@@ hw/rtl/dapsk_phase_ctrl.sv @@
module dapsk_phase_ctrl #(
  parameter int SINE_ADDR_BITS  = dapsk_pkg::DEF_SINE_ADDR_BITS,
  parameter int PHASE_FRAC_BITS = dapsk_pkg::DEF_PHASE_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  dapsk_pkg::cfg_idx_t           cfg_index,
  input  logic [dapsk_pkg::CFG_W-1:0]   cfg_data,
  dapsk_in_if.sink                      in_ch,
  input  logic                          s1_ready,
  output logic                          s1_valid,
  output logic [SINE_ADDR_BITS-1:0]     s1_addr,
  output dapsk_pkg::dapsk_flags_t       s1_flags
);
  import dapsk_pkg::*;

  localparam int PHASE_W = PHASE_FRAC_BITS + PHASE_INT_BITS;
  localparam int UP      = (PHASE_FRAC_BITS >= INC_W) ? PHASE_FRAC_BITS - INC_W : 0;
  localparam int DOWN    = (PHASE_FRAC_BITS < INC_W) ? INC_W - PHASE_FRAC_BITS : 0;
  localparam int WIDE_W  = INC_W + UP;

  logic [INC_W-1:0]   phase_inc_r;
  logic [CPS_W-1:0]   cycles_r;
  logic [TRAIN_W-1:0] training_r;

  logic [PHASE_W-1:0] carrier_phase_r, carrier_phase_nxt;
  logic [1:0]         quad_r, quad_nxt;
  logic               high_amp_r, high_amp_nxt;
  logic [TRAIN_W-1:0] train_cnt_r, train_cnt_nxt;
  logic               loading_r, loading_nxt;
  logic               taken;

  logic                      s1_valid_r;
  logic [SINE_ADDR_BITS-1:0] s1_addr_r, s1_addr_nxt;
  dapsk_flags_t              s1_flags_r;

  logic [WIDE_W-1:0]  inc_wide;
  logic [PHASE_W-1:0] inc;
  logic [PHASE_W-1:0] period;
  logic               accept;

  assign in_ch.ready = !s1_valid_r || s1_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // rescale the 32-bit step to the accumulator's fraction width
  assign inc_wide = {phase_inc_r, {UP{1'b0}}} >> DOWN;
  assign inc      = PHASE_W'(inc_wide);
  assign period   = {cycles_r, {PHASE_FRAC_BITS{1'b0}}};

  always_comb begin
    train_cnt_nxt     = in_ch.cmd ? '0 : train_cnt_r;
    loading_nxt       = in_ch.cmd ? 1'b0 : loading_r;
    high_amp_nxt      = in_ch.cmd ? 1'b0 : high_amp_r;
    quad_nxt          = quad_r;
    carrier_phase_nxt = carrier_phase_r;
    taken             = 1'b0;
    if (carrier_phase_r > period) begin
      carrier_phase_nxt = carrier_phase_r - period;
      if (train_cnt_nxt >= training_r) begin
        loading_nxt = 1'b1;
      end
      if (!loading_nxt) begin
        if (train_cnt_nxt != TRAIN_CNT_MAX) begin
          train_cnt_nxt = train_cnt_nxt + 1'b1;
        end
      end else begin
        taken = 1'b1;
        if (in_ch.symbol_present) begin
          quad_nxt = quad_r + in_ch.symbol[1:0];
          if (in_ch.symbol[2]) begin
            high_amp_nxt = !high_amp_nxt;
          end
        end
      end
    end
    carrier_phase_nxt = carrier_phase_nxt + inc;
    s1_addr_nxt = carrier_phase_nxt[PHASE_FRAC_BITS-1 -: SINE_ADDR_BITS]
                + {quad_nxt, {(SINE_ADDR_BITS-2){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_inc_r <= RST_PHASE_INC;
      cycles_r    <= RST_CYCLES;
      training_r  <= RST_TRAINING;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PHASE_INC: phase_inc_r <= cfg_data[INC_W-1:0];
        CFG_CYCLES:    cycles_r    <= cfg_data[CPS_W-1:0];
        CFG_TRAINING:  training_r  <= cfg_data[TRAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carrier_phase_r <= '0;
      quad_r          <= '0;
      high_amp_r      <= 1'b0;
      train_cnt_r     <= '0;
      loading_r       <= 1'b0;
      s1_valid_r      <= 1'b0;
    end else begin
      if (accept) begin
        carrier_phase_r <= carrier_phase_nxt;
        quad_r          <= quad_nxt;
        high_amp_r      <= high_amp_nxt;
        train_cnt_r     <= train_cnt_nxt;
        loading_r       <= loading_nxt;
        s1_valid_r      <= 1'b1;
      end else if (s1_ready) begin
        s1_valid_r      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr_r                <= s1_addr_nxt;
      s1_flags_r.high_amp      <= high_amp_nxt;
      s1_flags_r.symbol_taken  <= taken;
      s1_flags_r.in_training   <= !loading_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_addr  = s1_addr_r;
  assign s1_flags = s1_flags_r;

endmodule

@@ hw/rtl/dapsk_sine_out.sv @@
module dapsk_sine_out #(
  parameter int SINE_ADDR_BITS = dapsk_pkg::DEF_SINE_ADDR_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      s1_valid,
  input  logic [SINE_ADDR_BITS-1:0] s1_addr,
  input  dapsk_pkg::dapsk_flags_t   s1_flags,
  output logic                      s1_ready,
  dapsk_out_if.source               out_ch
);
  import dapsk_pkg::*;

  localparam int QTR_BITS = SINE_ADDR_BITS - 2;
  localparam int QUARTER  = 1 << QTR_BITS;

  logic [SINE_W-1:0]          rom [QUARTER+1];
  logic [1:0]                 quad;
  logic [QTR_BITS-1:0]        rem;
  logic [QTR_BITS:0]          idx;
  logic signed [SAMPLE_W-1:0] base;
  logic signed [SAMPLE_W-1:0] sample_nxt;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  dapsk_flags_t               flags_r;

  for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
    assign rom[g] = quarter_sine(g, SINE_ADDR_BITS);
  end

  assign quad = s1_addr[SINE_ADDR_BITS-1 -: 2];
  assign rem  = s1_addr[QTR_BITS-1:0];

  always_comb begin
    // mirror odd quadrants, negate the lower half cycle
    idx        = quad[0] ? (QTR_BITS+1)'(QUARTER) - {1'b0, rem} : {1'b0, rem};
    base       = quad[1] ? -$signed({2'b00, rom[idx]}) : $signed({2'b00, rom[idx]});
    sample_nxt = s1_flags.high_amp ? base + (base <<< 1) : base;
  end

  assign s1_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_ready) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid) begin
      sample_r <= sample_nxt;
      flags_r  <= s1_flags;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.sample       = sample_r;
  assign out_ch.symbol_taken = flags_r.symbol_taken;
  assign out_ch.in_training  = flags_r.in_training;

endmodule

@@ hw/rtl/differential_apsk_modulator_top.sv @@
// Pipeline: a result is shown after its input transfer passes the phase/state
//   update into an address register, then the sine lookup into the result register.
// Throughput: one sample per cycle while the output sink does not stall the pipeline.
// Reset: synchronous, active low; clears the accumulator, quadrant offset, amplitude,
//   training state and both pipeline valids, and loads the register defaults.
module differential_apsk_modulator_top #(
  parameter int SINE_ADDR_BITS  = dapsk_pkg::DEF_SINE_ADDR_BITS,
  parameter int PHASE_FRAC_BITS = dapsk_pkg::DEF_PHASE_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  dapsk_pkg::cfg_idx_t         cfg_index,
  input  logic [dapsk_pkg::CFG_W-1:0] cfg_data,
  dapsk_in_if.sink                    in_ch,
  dapsk_out_if.source                 out_ch
);
  import dapsk_pkg::*;

  // Stage 1 handshake: address and per-sample flags travel together.
  logic                      s1_valid;
  logic                      s1_ready;
  logic [SINE_ADDR_BITS-1:0] s1_addr;
  dapsk_flags_t              s1_flags;

  // Advance the carrier, handle symbol boundaries and training, form the
  // sine address including the differential quadrant offset.
  dapsk_phase_ctrl #(
    .SINE_ADDR_BITS  (SINE_ADDR_BITS),
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_phase_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .s1_ready  (s1_ready),
    .s1_valid  (s1_valid),
    .s1_addr   (s1_addr),
    .s1_flags  (s1_flags)
  );

  // Look up the quarter-wave table, apply sign and amplitude, hold the
  // result until the sink takes the transfer.
  dapsk_sine_out #(
    .SINE_ADDR_BITS (SINE_ADDR_BITS)
  ) u_sine_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_addr  (s1_addr),
    .s1_flags (s1_flags),
    .s1_ready (s1_ready),
    .out_ch   (out_ch)
  );

  // Training never consumes a symbol.
  a_no_take_in_training: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.in_training) |-> !out_ch.symbol_taken)
    else $error("symbol taken during training");

  // Amplitude stays one during training, so the sample stays within full scale.
  a_unit_amp_in_training: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.in_training) |->
      ($signed(out_ch.sample) <= 16'sd8192 && $signed(out_ch.sample) >= -16'sd8192))
    else $error("amplitude three during training");

  // Any sample lies within three times full scale.
  a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |->
      ($signed(out_ch.sample) <= 16'sd24576 && $signed(out_ch.sample) >= -16'sd24576))
    else $error("sample out of range");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

endmodule
